FILE: sv/hpack_huffman_byte_encoder_macros.svh
// assertion macros for the hpack huffman byte encoder
`ifndef HPACK_HUFFMAN_BYTE_ENCODER_MACROS_SVH
`define HPACK_HUFFMAN_BYTE_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define HPK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define HPK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HPK_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HPK_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/hpk_pkg.sv
// ----------------------------------------------------------------------------
// hpk_pkg
// code tables and shared types for the hpack huffman byte encoder
// ----------------------------------------------------------------------------
package hpk_pkg;

	localparam int CodeW  = 30;
	localparam int LenW   = 5;
	localparam int AccW   = 37;
	localparam int CntW   = 6;

	localparam logic [31:0] CODE_ROM [256] = '{
		32'h1ff8, 32'h7fffd8, 32'hfffffe2, 32'hfffffe3, 32'hfffffe4, 32'hfffffe5,
		32'hfffffe6, 32'hfffffe7, 32'hfffffe8, 32'hffffea, 32'h3ffffffc, 32'hfffffe9,
		32'hfffffea, 32'h3ffffffd, 32'hfffffeb, 32'hfffffec, 32'hfffffed, 32'hfffffee,
		32'hfffffef, 32'hffffff0, 32'hffffff1, 32'hffffff2, 32'h3ffffffe, 32'hffffff3,
		32'hffffff4, 32'hffffff5, 32'hffffff6, 32'hffffff7, 32'hffffff8, 32'hffffff9,
		32'hffffffa, 32'hffffffb, 32'h14, 32'h3f8, 32'h3f9, 32'hffa, 32'h1ff9, 32'h15,
		32'hf8, 32'h7fa, 32'h3fa, 32'h3fb, 32'hf9, 32'h7fb, 32'hfa, 32'h16, 32'h17,
		32'h18, 32'h0, 32'h1, 32'h2, 32'h19, 32'h1a, 32'h1b, 32'h1c, 32'h1d, 32'h1e,
		32'h1f, 32'h5c, 32'hfb, 32'h7ffc, 32'h20, 32'hffb, 32'h3fc, 32'h1ffa, 32'h21,
		32'h5d, 32'h5e, 32'h5f, 32'h60, 32'h61, 32'h62, 32'h63, 32'h64, 32'h65, 32'h66,
		32'h67, 32'h68, 32'h69, 32'h6a, 32'h6b, 32'h6c, 32'h6d, 32'h6e, 32'h6f, 32'h70,
		32'h71, 32'h72, 32'hfc, 32'h73, 32'hfd, 32'h1ffb, 32'h7fff0, 32'h1ffc, 32'h3ffc,
		32'h22, 32'h7ffd, 32'h3, 32'h23, 32'h4, 32'h24, 32'h5, 32'h25, 32'h26, 32'h27,
		32'h6, 32'h74, 32'h75, 32'h28, 32'h29, 32'h2a, 32'h7, 32'h2b, 32'h76, 32'h2c,
		32'h8, 32'h9, 32'h2d, 32'h77, 32'h78, 32'h79, 32'h7a, 32'h7b, 32'h7ffe, 32'h7fc,
		32'h3ffd, 32'h1ffd, 32'hffffffc, 32'hfffe6, 32'h3fffd2, 32'hfffe7, 32'hfffe8,
		32'h3fffd3, 32'h3fffd4, 32'h3fffd5, 32'h7fffd9, 32'h3fffd6, 32'h7fffda,
		32'h7fffdb, 32'h7fffdc, 32'h7fffdd, 32'h7fffde, 32'hffffeb, 32'h7fffdf,
		32'hffffec, 32'hffffed, 32'h3fffd7, 32'h7fffe0, 32'hffffee, 32'h7fffe1,
		32'h7fffe2, 32'h7fffe3, 32'h7fffe4, 32'h1fffdc, 32'h3fffd8, 32'h7fffe5,
		32'h3fffd9, 32'h7fffe6, 32'h7fffe7, 32'hffffef, 32'h3fffda, 32'h1fffdd,
		32'hfffe9, 32'h3fffdb, 32'h3fffdc, 32'h7fffe8, 32'h7fffe9, 32'h1fffde,
		32'h7fffea, 32'h3fffdd, 32'h3fffde, 32'hfffff0, 32'h1fffdf, 32'h3fffdf,
		32'h7fffeb, 32'h7fffec, 32'h1fffe0, 32'h1fffe1, 32'h3fffe0, 32'h1fffe2,
		32'h7fffed, 32'h3fffe1, 32'h7fffee, 32'h7fffef, 32'hfffea, 32'h3fffe2,
		32'h3fffe3, 32'h3fffe4, 32'h7ffff0, 32'h3fffe5, 32'h3fffe6, 32'h7ffff1,
		32'h3ffffe0, 32'h3ffffe1, 32'hfffeb, 32'h7fff1, 32'h3fffe7, 32'h7ffff2,
		32'h3fffe8, 32'h1ffffec, 32'h3ffffe2, 32'h3ffffe3, 32'h3ffffe4, 32'h7ffffde,
		32'h7ffffdf, 32'h3ffffe5, 32'hfffff1, 32'h1ffffed, 32'h7fff2, 32'h1fffe3,
		32'h3ffffe6, 32'h7ffffe0, 32'h7ffffe1, 32'h3ffffe7, 32'h7ffffe2, 32'hfffff2,
		32'h1fffe4, 32'h1fffe5, 32'h3ffffe8, 32'h3ffffe9, 32'hffffffd, 32'h7ffffe3,
		32'h7ffffe4, 32'h7ffffe5, 32'hfffec, 32'hfffff3, 32'hfffed, 32'h1fffe6,
		32'h3fffe9, 32'h1fffe7, 32'h1fffe8, 32'h7ffff3, 32'h3fffea, 32'h3fffeb,
		32'h1ffffee, 32'h1ffffef, 32'hfffff4, 32'hfffff5, 32'h3ffffea, 32'h7ffff4,
		32'h3ffffeb, 32'h7ffffe6, 32'h3ffffec, 32'h3ffffed, 32'h7ffffe7, 32'h7ffffe8,
		32'h7ffffe9, 32'h7ffffea, 32'h7ffffeb, 32'hffffffe, 32'h7ffffec, 32'h7ffffed,
		32'h7ffffee, 32'h7ffffef, 32'h7fffff0, 32'h3ffffee
	};

	localparam logic [7:0] SIZE_ROM [256] = '{
		13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
		28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
		 6, 10, 10, 12, 13,  6,  8, 11, 10, 10,  8, 11,  8,  6,  6,  6,
		 5,  5,  5,  6,  6,  6,  6,  6,  6,  6,  7,  8, 15,  6, 12, 10,
		13,  6,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,
		 7,  7,  7,  7,  7,  7,  7,  7,  8,  7,  8, 13, 19, 13, 14,  6,
		15,  5,  6,  5,  6,  5,  6,  6,  6,  5,  7,  7,  6,  6,  6,  5,
		 6,  7,  6,  5,  5,  6,  7,  7,  7,  7,  7, 15, 11, 14, 13, 28,
		20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
		24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
		22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
		21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
		26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
		19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
		20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
		26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
	};

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	// sequencer to shifter step controls
	typedef struct packed {
		logic load;
		logic step;
		logic clear;
	} sft_ctl_t;

	typedef struct packed {
		logic       has_byte;
		logic       has_pad;
		logic       byte_end;
		logic [7:0] byte_out;
		logic [7:0] pad_out;
	} sft_sts_t;

endpackage

FILE: sv/hpk_shifter.sv
// ----------------------------------------------------------------------------
// hpk_shifter
// bit accumulator with one shared byte extract unit, one octet per step
// ----------------------------------------------------------------------------
module hpk_shifter import hpk_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  sft_ctl_t       ctl,
	input  logic [7:0]     sym,
	output sft_sts_t       sts
);

	logic [AccW-1:0]  acc_q;
	logic [CntW-1:0]  cnt_q;
	logic [CodeW-1:0] code;
	logic [LenW-1:0]  len;
	logic [CntW-1:0]  nm8;
	logic [AccW-1:0]  shr;
	logic [2:0]       rem;
	logic [7:0]       restb;

	assign code = CODE_ROM[sym][CodeW-1:0];
	assign len  = SIZE_ROM[sym][LenW-1:0];
	assign nm8  = cnt_q - CntW'(8);
	assign shr  = acc_q >> nm8;
	assign rem  = cnt_q[2:0];
	assign restb = acc_q[7:0] << (4'd8 - {1'b0, rem});

	assign sts.has_byte = (cnt_q >= CntW'(8));
	assign sts.byte_end = (cnt_q == CntW'(8));
	assign sts.has_pad  = (cnt_q != '0) && (cnt_q < CntW'(8));
	assign sts.byte_out = shr[7:0];
	assign sts.pad_out  = restb | (8'hFF >> rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (ctl.load) begin
			acc_q <= ((acc_q & AccW'(7'h7F)) << len) | AccW'(code);
			cnt_q <= cnt_q + CntW'(len);
		end else if (ctl.step) begin
			cnt_q <= nm8;
		end
	end

endmodule

FILE: sv/hpack_huffman_byte_encoder.sv
// ----------------------------------------------------------------------------
// hpack_huffman_byte_encoder
// static hpack huffman encoder, one octet in, coded octets out
//
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    symbol, final_symbol
// out      out  out_valid/out_ready  coded_byte, end_of_string
//
// an octet is accepted in idle and its code is added to the bit store in load;
// emit then sends the coded octets (up to five) and returns to idle once none
// is left to send, or with the pad octet when the string ends on a pad octet
// a stalled output holds the sequencer in emit, in_ready stays low until idle
// reset clears the pending bit store and returns to idle
// ----------------------------------------------------------------------------
`include "hpack_huffman_byte_encoder_macros.svh"
module hpack_huffman_byte_encoder import hpk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] symbol,
	input  logic       final_symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] coded_byte,
	output logic       end_of_string
);

	state_t     state_q;
	logic [7:0] sym_q;
	logic       last_q;
	sft_ctl_t   ctl;
	sft_sts_t   sts;
	logic       fire;

	hpk_shifter u_sft (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sym    (sym_q),
		.sts    (sts)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT) && (sts.has_byte || (last_q && sts.has_pad));
	assign fire      = out_valid && out_ready;
	assign coded_byte = sts.has_byte ? sts.byte_out : sts.pad_out;
	assign end_of_string = last_q && (sts.has_pad || sts.byte_end);

	always_comb begin
		ctl.load  = (state_q == ST_LOAD);
		ctl.step  = fire && sts.has_byte;
		ctl.clear = (state_q == ST_EMIT) && last_q && (fire && !sts.has_byte);
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sym_q  <= symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOAD;
						last_q  <= final_symbol;
					end
				end
				ST_LOAD: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (!out_valid) begin
						state_q <= ST_IDLE;
					end else if (fire && last_q && !sts.has_byte) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`HPK_ASSERT_IMPL(a_busy_no_ready, clk, arst_n, state_q != ST_IDLE, !in_ready)
	`HPK_ASSERT_NEXT(a_load_to_emit, clk, arst_n, state_q == ST_LOAD, state_q == ST_EMIT)
	`HPK_ASSERT_IMPL(a_out_in_emit, clk, arst_n, out_valid, state_q == ST_EMIT)

endmodule

FILE: tb/tb_hpack_huffman_byte_encoder.sv
// ----------------------------------------------------------------------------
// tb_hpack_huffman_byte_encoder
// self-checking bench for the static hpack huffman byte encoder: strings of
// octets are driven under several idle/stall mixes, a bit-level predictor
// builds the expected coded octets and the monitor checks them in order
// ----------------------------------------------------------------------------
module tb_hpack_huffman_byte_encoder;
	import hpk_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] sym;
		logic       last;
	} octet_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       eos;
	} coded_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] symbol;
	logic       final_symbol;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] coded_byte;
	logic       end_of_string;

	octet_t pending_octets[$];
	coded_t expected_bytes[$];
	logic [6:0] acc_bits;
	int unsigned acc_count;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_sender;
	int errors;
	int bytes_seen;
	int strings_seen;
	int octets_sent;
	longint cycles;

	hpack_huffman_byte_encoder u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.symbol(symbol), .final_symbol(final_symbol),
		.out_valid(out_valid), .out_ready(out_ready),
		.coded_byte(coded_byte), .end_of_string(end_of_string)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic encode_octet(input octet_t o);
		logic [63:0] acc;
		int unsigned len;
		int unsigned n;
		coded_t c;
		len = SIZE_ROM[o.sym];
		n = acc_count + len;
		acc = ({57'd0, acc_bits} << len) | {32'd0, CODE_ROM[o.sym]};
		while (n >= 8) begin
			n -= 8;
			c.code_byte = 8'((acc >> n) & 64'hff);
			c.eos = 1'b0;
			expected_bytes.push_back(c);
		end
		acc &= (64'd1 << n) - 64'd1;
		if (o.last) begin
			if (n > 0) begin
				c.code_byte = 8'(((acc << (8 - n)) | (64'hff >> n)) & 64'hff);
				c.eos = 1'b1;
				expected_bytes.push_back(c);
			end else begin
				expected_bytes[$].eos = 1'b1;
			end
			acc_bits = '0;
			acc_count = 0;
		end else begin
			acc_bits = acc[6:0];
			acc_count = n;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			symbol <= '0;
			final_symbol <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (in_valid && in_ready) begin
				encode_octet(octet_t'{symbol, final_symbol});
				octets_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_octets.size() > 0 && !hold_sender
						&& $urandom_range(99) >= send_idle_pct) begin
					octet_t o;
					o = pending_octets.pop_front();
					in_valid <= 1'b1;
					symbol <= o.sym;
					final_symbol <= o.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected transfer", coded_byte, 8'h00);
			end else begin
				coded_t e;
				e = expected_bytes.pop_front();
				if (coded_byte !== e.code_byte)
					report_mismatch("coded_byte", coded_byte, e.code_byte);
				if (end_of_string !== e.eos)
					report_mismatch("end_of_string", {7'd0, end_of_string}, {7'd0, e.eos});
				bytes_seen++;
				if (e.eos)
					strings_seen++;
			end
		end
		if (cycles > 400000) begin
			$display("timeout at cycle %0d", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic queue_string(input int len, input int kind);
		octet_t o;
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: o.sym = 8'($urandom_range(255));
				1: o.sym = 8'($urandom_range(32, 126));
				default: o.sym = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
					: 8'($urandom_range(48, 122));
			endcase
			o.last = (i == len - 1);
			pending_octets.push_back(o);
		end
	endtask

	task automatic drain_all();
		while (pending_octets.size() > 0 || in_valid || expected_bytes.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int n_octets);
		int queued;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		queued = 0;
		while (queued < n_octets) begin
			int len;
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			queue_string(len, $urandom_range(2));
			queued += len;
		end
		drain_all();
	endtask

	initial begin
		octet_t o;
		arst_n = 1'b0;
		acc_bits = '0;
		acc_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_sender = 1'b0;
		errors = 0;
		bytes_seen = 0;
		strings_seen = 0;
		octets_sent = 0;
		cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: shortest and longest codes, field extremes, byte-aligned ends
		o = '{8'd48, 1'b1}; pending_octets.push_back(o);
		o = '{8'd255, 1'b1}; pending_octets.push_back(o);
		o = '{8'd0, 1'b1}; pending_octets.push_back(o);
		o = '{8'd38, 1'b1}; pending_octets.push_back(o);
		o = '{8'd10, 1'b0}; pending_octets.push_back(o);
		o = '{8'd13, 1'b0}; pending_octets.push_back(o);
		o = '{8'd22, 1'b1}; pending_octets.push_back(o);
		o = '{8'd48, 1'b0}; pending_octets.push_back(o);
		o = '{8'd49, 1'b0}; pending_octets.push_back(o);
		o = '{8'd97, 1'b0}; pending_octets.push_back(o);
		o = '{8'd38, 1'b1}; pending_octets.push_back(o);
		o = '{8'd170, 1'b0}; pending_octets.push_back(o);
		o = '{8'd85, 1'b0}; pending_octets.push_back(o);
		o = '{8'd127, 1'b0}; pending_octets.push_back(o);
		o = '{8'd128, 1'b1}; pending_octets.push_back(o);
		o = '{8'd32, 1'b0}; pending_octets.push_back(o);
		o = '{8'd32, 1'b0}; pending_octets.push_back(o);
		o = '{8'd32, 1'b0}; pending_octets.push_back(o);
		o = '{8'd32, 1'b1}; pending_octets.push_back(o);
		drain_all();

		run_phase(0, 0, 110);
		run_phase(73, 0, 110);
		run_phase(0, 73, 110);
		// sender held until all coded octets are out, then released
		queue_string(6, 0);
		while (pending_octets.size() > 0 || in_valid)
			@(posedge clk);
		hold_sender = 1'b1;
		queue_string(6, 0);
		while (expected_bytes.size() > 0)
			@(posedge clk);
		hold_sender = 1'b0;
		drain_all();
		run_phase(10, 10, 110);

		$display("sent %0d octets, checked %0d coded octets over %0d strings",
			octets_sent, bytes_seen, strings_seen);
		$display("phases: back-to-back, sparse sender, slow receiver, mixed");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
